// ===== hdl/epdm_pkg.sv =====
// Shared constants and types for the echo pulse distance meter.
`timescale 1ns / 1ps
`default_nettype none
package epdm_pkg;

    // Register and field widths
    localparam int TICK_W      = 27;
    localparam int SPEED_W     = 19;
    localparam int DEB_W       = 8;
    localparam int DIST_W      = 17;
    localparam int TICKS_W     = 16;
    localparam int QUOT_W      = DIST_W + 1;
    localparam int CFG_DATA_W  = TICK_W;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_TDATA_W = ((DIST_W + TICKS_W + 7) / 8) * 8;

    // Default capture timer width
    localparam int CAPTURE_BITS_DEF = 16;

    // Register reset values
    localparam logic [TICK_W-1:0]  TICK_RATE_RST   = TICK_W'(1000000);
    localparam logic [SPEED_W-1:0] SOUND_SPEED_RST = SPEED_W'(346675);
    localparam logic [DEB_W-1:0]   DEBOUNCE_RST    = DEB_W'(2);

    // Saturated distance
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_SPEED = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = CFG_IDX_W'(2);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_DEC
    } seq_state_t;

endpackage
`default_nettype wire

// ===== hdl/epdm_alu.sv =====
// Shared add/subtract unit used by the multiply and divide sequencer.
`timescale 1ns / 1ps
`default_nettype none
module epdm_alu #(
    parameter int W = 46
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic         sub,
    output logic      [W-1:0] sum,
    output logic              carry
);

    logic [W:0] full;

    // Add b, or subtract it as a plus inverted b plus one; when subtracting, carry means a >= b
    assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
    assign sum   = full[W-1:0];
    assign carry = full[W];

endmodule
`default_nettype wire

// ===== hdl/echo_pulse_distance_meter_top.sv =====
// Echo pulse distance meter: edge pairing, shift-add multiply, restoring divide, debounce.
// A rising-edge word is absorbed without leaving idle; a falling-edge word runs through the
// multiply, range check, divide and debounce states to the output register; a zero tick rate
// skips to debounce. A falling edge holds the input until the sequencer is idle again; the
// shared adder runs one multiply bit, then one quotient bit, per cycle.
// Reset: rst_n clears control state and loads register defaults; next edge is rising.
`timescale 1ns / 1ps
`default_nettype none
module echo_pulse_distance_meter_top #(
    parameter int CAPTURE_BITS = epdm_pkg::CAPTURE_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // Configuration write port
    input  wire logic                                   wr_en,
    input  wire logic [epdm_pkg::CFG_IDX_W-1:0]         wr_index,
    input  wire logic [epdm_pkg::CFG_DATA_W-1:0]        wr_data,
    // Input stream
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [((CAPTURE_BITS+7)/8)*8-1:0]      s_tdata,  // capture_time
    // Output stream
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic      [epdm_pkg::OUT_TDATA_W-1:0]       m_tdata   // distance_mm, pulse_ticks
);

    localparam int PROD_W   = CAPTURE_BITS + epdm_pkg::SPEED_W;
    localparam int SCALED_W = epdm_pkg::TICK_W + epdm_pkg::QUOT_W;
    localparam int ALU_W    = (PROD_W > SCALED_W) ? PROD_W : SCALED_W;
    localparam int CNT_MAX  = (CAPTURE_BITS > epdm_pkg::QUOT_W) ? CAPTURE_BITS
                                                                : epdm_pkg::QUOT_W;
    localparam int CNT_W    = $clog2(CNT_MAX);
    localparam int PAD_W    = epdm_pkg::OUT_TDATA_W - epdm_pkg::DIST_W - epdm_pkg::TICKS_W;

    // Configuration registers
    logic [epdm_pkg::TICK_W-1:0]  tick_reg;
    logic [epdm_pkg::SPEED_W-1:0] speed_reg;
    logic [epdm_pkg::DEB_W-1:0]   deb_reg;

    // Control state
    epdm_pkg::seq_state_t state_reg, state_next;
    logic                         await_reg, await_next;
    logic                         oval_reg, oval_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [epdm_pkg::DIST_W-1:0]  last_reg, last_next;
    logic [CAPTURE_BITS-1:0]      rise_reg, rise_next;

    // Datapath
    logic [CAPTURE_BITS-1:0]      width_reg, width_next;
    logic [CAPTURE_BITS-1:0]      wsh_reg, wsh_next;
    logic [ALU_W-1:0]             acc_reg, acc_next;
    logic [epdm_pkg::TICK_W-1:0]  rem_reg, rem_next;
    logic [epdm_pkg::QUOT_W-1:0]  lo_reg, lo_next;
    logic [epdm_pkg::QUOT_W-1:0]  q_reg, q_next;
    logic [epdm_pkg::DIST_W-1:0]  dist_reg, dist_next;
    logic [epdm_pkg::DIST_W-1:0]  odist_reg, odist_next;
    logic [epdm_pkg::TICKS_W-1:0] oticks_reg, oticks_next;

    // Shared unit connections
    logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
    logic             alu_sub, alu_carry;

    logic [CAPTURE_BITS-1:0]     cap;
    logic [epdm_pkg::DIST_W-1:0] diff;

    epdm_alu #(
        .W (ALU_W)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    assign cap      = s_tdata[CAPTURE_BITS-1:0];
    assign s_tready = (state_reg == epdm_pkg::ST_IDLE);
    assign m_tvalid = oval_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, oticks_reg, odist_reg};
    assign diff     = (dist_reg >= last_reg) ? (dist_reg - last_reg) : (last_reg - dist_reg);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= epdm_pkg::TICK_RATE_RST;
            speed_reg <= epdm_pkg::SOUND_SPEED_RST;
            deb_reg   <= epdm_pkg::DEBOUNCE_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                epdm_pkg::REG_TICK_RATE:   tick_reg  <= wr_data[epdm_pkg::TICK_W-1:0];
                epdm_pkg::REG_SOUND_SPEED: speed_reg <= wr_data[epdm_pkg::SPEED_W-1:0];
                epdm_pkg::REG_DEBOUNCE:    deb_reg   <= wr_data[epdm_pkg::DEB_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= epdm_pkg::ST_IDLE;
            await_reg <= 1'b0;
            oval_reg  <= 1'b0;
            cnt_reg   <= '0;
            last_reg  <= '0;
            rise_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            await_reg <= await_next;
            oval_reg  <= oval_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            rise_reg  <= rise_next;
        end
    end

    // Hold datapath words
    always_ff @(posedge clk)
    begin
        width_reg  <= width_next;
        wsh_reg    <= wsh_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        lo_reg     <= lo_next;
        q_reg      <= q_next;
        dist_reg   <= dist_next;
        odist_reg  <= odist_next;
        oticks_reg <= oticks_next;
    end

    // Sequence the multiply, range check, divide and debounce
    always_comb
    begin
        state_next  = state_reg;
        await_next  = await_reg;
        oval_next   = oval_reg && !m_tready;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        rise_next   = rise_reg;
        width_next  = width_reg;
        wsh_next    = wsh_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        lo_next     = lo_reg;
        q_next      = q_reg;
        dist_next   = dist_reg;
        odist_next  = odist_reg;
        oticks_next = oticks_reg;
        alu_a       = '0;
        alu_b       = '0;
        alu_sub     = 1'b0;

        case (state_reg)
            epdm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (!await_reg)
                    begin
                        // Rising edge: store its time
                        rise_next  = cap;
                        await_next = 1'b1;
                    end
                    else
                    begin
                        // Falling edge: form the width modulo the timer range
                        await_next = 1'b0;
                        width_next = cap - rise_reg;
                        wsh_next   = cap - rise_reg;
                        acc_next   = '0;
                        cnt_next   = CNT_W'(CAPTURE_BITS - 1);
                        if (tick_reg == '0)
                        begin
                            dist_next  = epdm_pkg::DIST_MAX;
                            state_next = epdm_pkg::ST_DEC;
                        end
                        else
                        begin
                            state_next = epdm_pkg::ST_MUL;
                        end
                    end
                end
            end

            epdm_pkg::ST_MUL:
            begin
                // One width bit per cycle, most significant first
                alu_a    = acc_reg << 1;
                alu_b    = wsh_reg[CAPTURE_BITS-1] ? ALU_W'(speed_reg) : '0;
                acc_next = alu_sum;
                wsh_next = wsh_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = epdm_pkg::ST_CHK;
                end
            end

            epdm_pkg::ST_CHK:
            begin
                // A quotient wider than QUOT_W bits saturates the distance
                alu_a   = acc_reg;
                alu_b   = ALU_W'(tick_reg) << epdm_pkg::QUOT_W;
                alu_sub = 1'b1;
                if (alu_carry)
                begin
                    dist_next  = epdm_pkg::DIST_MAX;
                    state_next = epdm_pkg::ST_DEC;
                end
                else
                begin
                    rem_next   = acc_reg[epdm_pkg::QUOT_W +: epdm_pkg::TICK_W];
                    lo_next    = acc_reg[epdm_pkg::QUOT_W-1:0];
                    q_next     = '0;
                    cnt_next   = CNT_W'(epdm_pkg::QUOT_W - 1);
                    state_next = epdm_pkg::ST_DIV;
                end
            end

            epdm_pkg::ST_DIV:
            begin
                // Restoring divide, one quotient bit per cycle
                alu_a   = ALU_W'({rem_reg, lo_reg[epdm_pkg::QUOT_W-1]});
                alu_b   = ALU_W'(tick_reg);
                alu_sub = 1'b1;
                if (alu_carry)
                begin
                    rem_next = alu_sum[epdm_pkg::TICK_W-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[epdm_pkg::TICK_W-2:0], lo_reg[epdm_pkg::QUOT_W-1]};
                end
                q_next   = {q_reg[epdm_pkg::QUOT_W-2:0], alu_carry};
                lo_next  = lo_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // Halve the quotient
                    dist_next  = q_next[epdm_pkg::QUOT_W-1:1];
                    state_next = epdm_pkg::ST_DEC;
                end
            end

            epdm_pkg::ST_DEC:
            begin
                // Report only a change beyond the debounce threshold
                if (diff > epdm_pkg::DIST_W'(deb_reg))
                begin
                    if (!oval_reg || m_tready)
                    begin
                        oval_next   = 1'b1;
                        odist_next  = dist_reg;
                        oticks_next = epdm_pkg::TICKS_W'(width_reg);
                        last_next   = dist_reg;
                        state_next  = epdm_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = epdm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = epdm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== tb/sv/echo_range_monitor.sv =====
// Checker for the echo pulse distance meter: predicts each distance word and compares it.
`timescale 1ns / 1ps
module echo_range_monitor (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [epdm_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [epdm_pkg::CFG_DATA_W-1:0]      wr_data,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [epdm_pkg::TICKS_W-1:0]         s_tdata,    // capture_time
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [epdm_pkg::OUT_TDATA_W-1:0]     m_tdata,    // distance_mm, pulse_ticks
    output int                                   outstanding,
    output int                                   mismatches
);

    typedef struct packed {
        logic [epdm_pkg::DIST_W-1:0]  distance;
        logic [epdm_pkg::TICKS_W-1:0] ticks;
    } range_t;

    range_t              pending_ranges[$];
    range_t              want;
    range_t              got;
    int                  fail_count;

    // Shadow copy of the registers and the edge-pairing state
    logic [epdm_pkg::TICK_W-1:0]   tick_rate;
    logic [epdm_pkg::SPEED_W-1:0]  sound_speed;
    logic [epdm_pkg::DEB_W-1:0]    debounce;
    logic                          awaiting_fall;
    logic [epdm_pkg::TICKS_W-1:0]  rise_mark;
    logic [epdm_pkg::DIST_W-1:0]   last_dist;
    logic [epdm_pkg::TICKS_W-1:0]  pulse_width;
    logic [epdm_pkg::DIST_W-1:0]   new_dist;
    logic [epdm_pkg::DIST_W-1:0]   dist_change;

    // Convert a pulse width in ticks to a one-way distance in mm, saturating
    function automatic logic [epdm_pkg::DIST_W-1:0] calc_distance(
        input logic [epdm_pkg::TICKS_W-1:0] width);
        logic [63:0] product;
        logic [63:0] halved;
        if (tick_rate == '0)
            return epdm_pkg::DIST_MAX;
        product = 64'(width) * 64'(sound_speed);
        halved  = (product / 64'(tick_rate)) >> 1;
        if (halved > 64'(epdm_pkg::DIST_MAX))
            return epdm_pkg::DIST_MAX;
        return halved[epdm_pkg::DIST_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate     = epdm_pkg::TICK_RATE_RST;
            sound_speed   = epdm_pkg::SOUND_SPEED_RST;
            debounce      = epdm_pkg::DEBOUNCE_RST;
            awaiting_fall = 1'b0;
            rise_mark     = '0;
            last_dist     = '0;
            fail_count    = 0;
            pending_ranges.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            // Track register writes; unused indexes are dropped
            if (wr_en)
            begin
                case (wr_index)
                    epdm_pkg::REG_TICK_RATE:
                        tick_rate   = wr_data[epdm_pkg::TICK_W-1:0];
                    epdm_pkg::REG_SOUND_SPEED:
                        sound_speed = wr_data[epdm_pkg::SPEED_W-1:0];
                    epdm_pkg::REG_DEBOUNCE:
                        debounce    = wr_data[epdm_pkg::DEB_W-1:0];
                    default: ;
                endcase
            end

            // Pair edges; a falling edge may queue one distance word
            if (s_tvalid && s_tready)
            begin
                if (!awaiting_fall)
                begin
                    rise_mark     = s_tdata;
                    awaiting_fall = 1'b1;
                end
                else
                begin
                    awaiting_fall = 1'b0;
                    pulse_width   = s_tdata - rise_mark;
                    new_dist      = calc_distance(pulse_width);
                    dist_change   = (new_dist > last_dist) ? new_dist - last_dist
                                                           : last_dist - new_dist;
                    if (dist_change > epdm_pkg::DIST_W'(debounce))
                    begin
                        last_dist      = new_dist;
                        want.distance  = new_dist;
                        want.ticks     = pulse_width;
                        pending_ranges.push_back(want);
                    end
                end
            end

            // Compare each output word with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got.distance = m_tdata[epdm_pkg::DIST_W-1:0];
                got.ticks    = m_tdata[epdm_pkg::DIST_W +: epdm_pkg::TICKS_W];
                if (pending_ranges.size() == 0)
                begin
                    $error("unexpected word: distance_mm %0d, pulse_ticks %0d",
                           got.distance, got.ticks);
                    fail_count++;
                end
                else
                begin
                    want = pending_ranges.pop_front();
                    if (got.distance !== want.distance)
                    begin
                        $error("distance_mm: expected %0d, got %0d",
                               want.distance, got.distance);
                        fail_count++;
                    end
                    if (got.ticks !== want.ticks)
                    begin
                        $error("pulse_ticks: expected %0d, got %0d", want.ticks, got.ticks);
                        fail_count++;
                    end
                end
            end

            outstanding <= pending_ranges.size();
            mismatches  <= fail_count;
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the echo pulse distance meter: stimulus, output back-pressure, verdict.
`timescale 1ns / 1ps
module tb;

    localparam int S_TDATA_W     = ((epdm_pkg::CAPTURE_BITS_DEF + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 60;
    localparam int LONG_STALL    = 400;
    localparam int PHASE_PAIRS   = 40;
    localparam int CYCLE_LIMIT   = 600000;
    localparam logic [epdm_pkg::CFG_IDX_W-1:0] REG_UNUSED = epdm_pkg::CFG_IDX_W'(3);

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                wr_en = 1'b0;
    logic [epdm_pkg::CFG_IDX_W-1:0]      wr_index = '0;
    logic [epdm_pkg::CFG_DATA_W-1:0]     wr_data = '0;
    logic                                s_tvalid = 1'b0;
    wire                                 s_tready;
    logic [S_TDATA_W-1:0]                s_tdata = '0;
    wire                                 m_tvalid;
    logic                                m_tready = 1'b0;
    wire  [epdm_pkg::OUT_TDATA_W-1:0]    m_tdata;

    int                                  outstanding;
    int                                  mismatches;
    int                                  cycle_count = 0;
    bit                                  tx_gaps = 1'b0;
    bit                                  rx_gaps = 1'b0;
    bit                                  hold_output = 1'b0;
    logic [epdm_pkg::TICKS_W-1:0]        last_width = '0;

    always #4 clk = ~clk;

    echo_pulse_distance_meter_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    echo_range_monitor u_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[echo_pulse_distance_meter_top] ERROR");
            $finish;
        end
    end

    // Output back-pressure: random short stalls, one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                hold_output = 1'b0;
                m_tready <= 1'b1;
            end
            else if (rx_gaps && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Offer one capture word and hold it until accepted
    task automatic send_word(input logic [epdm_pkg::TICKS_W-1:0] value);
        s_tdata  <= value;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic send_pair(input logic [epdm_pkg::TICKS_W-1:0] rise,
                             input logic [epdm_pkg::TICKS_W-1:0] fall);
        send_word(rise);
        send_word(fall);
    endtask

    // Drop valid, wait for every predicted word, then let the arithmetic settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [epdm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [epdm_pkg::CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
    endtask

    // Load all three registers plus a stray write to the unused index
    task automatic set_config(input logic [epdm_pkg::TICK_W-1:0] tick,
                              input logic [epdm_pkg::SPEED_W-1:0] speed,
                              input logic [epdm_pkg::DEB_W-1:0] deb);
        logic [epdm_pkg::CFG_DATA_W-1:0] data;
        write_reg(epdm_pkg::REG_TICK_RATE, tick);
        data = epdm_pkg::CFG_DATA_W'($urandom);
        data[epdm_pkg::SPEED_W-1:0] = speed;
        write_reg(epdm_pkg::REG_SOUND_SPEED, data);
        data = epdm_pkg::CFG_DATA_W'($urandom);
        data[epdm_pkg::DEB_W-1:0] = deb;
        write_reg(epdm_pkg::REG_DEBOUNCE, data);
        write_reg(REG_UNUSED, epdm_pkg::CFG_DATA_W'($urandom));
        wr_en <= 1'b0;
    endtask

    // Random echo pairs with occasional lone edges that shift the pairing
    task automatic run_pairs(input int count);
        logic [epdm_pkg::TICKS_W-1:0] rise;
        logic [epdm_pkg::TICKS_W-1:0] width;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_word(epdm_pkg::TICKS_W'($urandom));
            rise = epdm_pkg::TICKS_W'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: width = epdm_pkg::TICKS_W'($urandom_range(0, 3000));
                4, 5:       width = epdm_pkg::TICKS_W'($urandom);
                6, 7:       width = last_width + epdm_pkg::TICKS_W'($urandom_range(0, 40))
                                    - epdm_pkg::TICKS_W'(20);
                8:          width = $urandom_range(0, 1) ? '1 : '0;
                default:
                begin
                    rise  = epdm_pkg::TICKS_W'($urandom_range(16'hFF00, 16'hFFFF));
                    width = epdm_pkg::TICKS_W'($urandom_range(0, 16'h0200));
                end
            endcase
            last_width = width;
            send_pair(rise, rise + width);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        // Directed edges at reset register values
        send_pair(16'h0000, 16'h0000);            // equal edge times, no change
        send_pair(16'h1234, 16'h1234 + 16'd1000);
        send_pair(16'hFFF0, 16'h0010);            // timer wrap
        send_pair(16'h0000, 16'hFFFF);            // widest pulse
        send_pair(16'hFFFF, 16'hFFFE);            // same width, held by debounce
        send_pair(16'h8000, 16'h7FF5);            // just inside debounce
        send_pair(16'h8000, 16'h7FE0);            // just past it
        send_pair(16'hAAAA, 16'h5555);
        send_pair(16'h5555, 16'hAAAA);
        send_word(16'h0001);                      // lone edge flips the pairing
        send_pair(16'h0002, 16'h0300);
        send_word(16'h0004);
        send_pair(16'h0000, 16'h0000);
        wait_idle();

        // Register extremes
        set_config(epdm_pkg::TICK_W'(72000000), epdm_pkg::SPEED_W'(300000),
                   epdm_pkg::DEB_W'(0));
        run_pairs(PHASE_PAIRS);
        wait_idle();
        set_config(epdm_pkg::TICK_W'(100000), epdm_pkg::SPEED_W'(400000),
                   epdm_pkg::DEB_W'(255));
        run_pairs(PHASE_PAIRS);
        wait_idle();
        // Zero tick rate
        set_config('0, epdm_pkg::SPEED_W'($urandom), epdm_pkg::DEB_W'($urandom));
        run_pairs(PHASE_PAIRS);
        wait_idle();
        // Saturating distances, then zero distances
        set_config(epdm_pkg::TICK_W'(1), '1, epdm_pkg::DEB_W'(0));
        run_pairs(PHASE_PAIRS);
        wait_idle();
        set_config('1, '0, epdm_pkg::DEB_W'(0));
        run_pairs(PHASE_PAIRS);
        wait_idle();

        // Full-width random registers, with a pause for every result midway
        set_config(epdm_pkg::TICK_W'($urandom), epdm_pkg::SPEED_W'($urandom),
                   epdm_pkg::DEB_W'($urandom));
        run_pairs(PHASE_PAIRS / 2);
        wait_idle();
        run_pairs(PHASE_PAIRS / 2);
        wait_idle();

        // Long output hold while input keeps coming
        set_config(epdm_pkg::TICK_W'($urandom_range(100000, 72000000)),
                   epdm_pkg::SPEED_W'($urandom_range(300000, 400000)),
                   epdm_pkg::DEB_W'($urandom_range(0, 8)));
        hold_output = 1'b1;
        run_pairs(PHASE_PAIRS);
        wait_idle();

        // Random settings in the working range
        for (int p = 0; p < 4; p++)
        begin
            set_config(epdm_pkg::TICK_W'($urandom_range(100000, 72000000)),
                       epdm_pkg::SPEED_W'($urandom_range(300000, 400000)),
                       epdm_pkg::DEB_W'($urandom_range(0, 255)));
            run_pairs(PHASE_PAIRS);
            wait_idle();
        end

        // Back to defaults at full rate, no stalls on either side
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        set_config(epdm_pkg::TICK_RATE_RST, epdm_pkg::SOUND_SPEED_RST,
                   epdm_pkg::DEBOUNCE_RST);
        run_pairs(PHASE_PAIRS + 10);
        wait_idle();

        if (mismatches == 0 && outstanding == 0)
            $display("[echo_pulse_distance_meter_top] OK");
        else
            $display("[echo_pulse_distance_meter_top] ERROR");
        $finish;
    end

endmodule
